FILE: design/udmf_pkg.sv
// ----------------------------------------------------------------------------
// udmf_pkg: shared types and constants for the unsigned division magic finder
// Widths, status codes and controller states used by the interfaces and core.
// ----------------------------------------------------------------------------
`default_nettype none

package udmf_pkg;

    localparam int DIV_W   = 32;
    localparam int MULT_W  = 32;
    localparam int SHIFT_W = 7;
    localparam int STAT_W  = 2;
    localparam int P_W     = 6;

    localparam logic [STAT_W-1:0] STAT_FOUND = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;

    // dividend bound 2^31-1 and the fixed nc for divisor three
    localparam logic [DIV_W-1:0] NC_OTHER = 32'h7fff_ffff;
    localparam logic [DIV_W-1:0] NC_THREE = 32'hffff_fffe;

    // steps to form (2^31 - 1) mod d before the search
    localparam logic [P_W-1:0] PRE_LAST    = 6'd31;
    localparam logic [P_W-1:0] LAST_P_THREE = 6'd63;
    localparam logic [P_W-1:0] LAST_P_OTHER = 6'd62;
    localparam logic [SHIFT_W-1:0] WORD_BITS = 7'd32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRE,
        S_SEARCH,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: design/udmf_if.sv
// ----------------------------------------------------------------------------
// udmf_if: request and result channels of the magic finder
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface udmf_in_if;
    logic                          valid;
    logic                          ready;
    logic [udmf_pkg::DIV_W-1:0]    divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);
endinterface

interface udmf_out_if;
    logic                              valid;
    logic                              ready;
    logic [udmf_pkg::MULT_W-1:0]       multiplier;
    logic signed [udmf_pkg::SHIFT_W-1:0] shift_amount;
    logic [udmf_pkg::STAT_W-1:0]       status;

    modport source (output valid, output multiplier, output shift_amount,
                    output status, input ready);
    modport sink   (input valid, input multiplier, input shift_amount,
                    input status, output ready);
endinterface

`default_nettype wire

FILE: design/unsigned_div_magic_finder_top.sv
// Flow: divisor zero, 1, 2, 4, 8 and above 2^31 go straight to emit; divisor
//   three goes straight to the search, and any other runs the pre-step first.
// Throughput: one request at a time, paced by the bit-serial
//   remainder/quotient recurrences (one bit per cycle).
// Reset: synchronous active-low i_rst_n clears control and the output valid.
// ----------------------------------------------------------------------------
// unsigned_div_magic_finder_top: multiplier and shift for division by constant
// Walks p upward, tracking (2^p-1) mod d, (2^p-1)/d and (2^p-1)/nc serially.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_div_magic_finder_top (
    input  wire              i_clk,
    input  wire              i_rst_n,
    udmf_in_if.sink          i_req,
    udmf_out_if.source       o_res
);

    udmf_pkg::t_state r_state, n_state;

    logic [udmf_pkg::DIV_W-1:0]   r_d;
    logic [udmf_pkg::DIV_W-1:0]   r_nc;
    logic [udmf_pkg::DIV_W-1:0]   r_rem;   // (2^p - 1) mod d
    logic [udmf_pkg::DIV_W-1:0]   r_r;     // (2^p - 1) mod nc
    logic [udmf_pkg::DIV_W:0]     r_q;     // (2^p - 1) / nc, saturates at bit 32
    logic [udmf_pkg::MULT_W-1:0]  r_qd;    // low bits of (2^p - 1) / d
    logic [udmf_pkg::P_W-1:0]     r_p;
    logic                         r_is3;

    logic [udmf_pkg::MULT_W-1:0]  r_res_mult;
    logic [udmf_pkg::SHIFT_W-1:0] r_res_shift;
    logic [udmf_pkg::STAT_W-1:0]  r_res_status;

    logic                         r_out_valid;
    logic [udmf_pkg::MULT_W-1:0]  r_out_mult;
    logic [udmf_pkg::SHIFT_W-1:0] r_out_shift;
    logic [udmf_pkg::STAT_W-1:0]  r_out_status;

    logic in_ready;
    logic out_free;
    logic out_load;
    logic accept;

    // request decode
    logic [udmf_pkg::DIV_W-1:0] req_d;
    logic d_zero, d_pow_small, d_big, d_three;
    logic [udmf_pkg::SHIFT_W-1:0] small_shift;

    // datapath
    logic [udmf_pkg::DIV_W:0]     rem_dbl, r_dbl, t_inc;
    logic                         rem_ge, r_ge;
    logic [udmf_pkg::DIV_W-1:0]   rem_nx, r_nx, delta, t_mod, nc_pre;
    logic [udmf_pkg::DIV_W:0]     q_nx;
    logic                         hit;
    logic [udmf_pkg::P_W-1:0]     last_p;
    logic [udmf_pkg::MULT_W-1:0]  mult;
    logic [udmf_pkg::SHIFT_W-1:0] shift_found;

    assign req_d       = i_req.divisor;
    assign d_zero      = (req_d == '0);
    assign d_pow_small = (req_d == 32'd1) || (req_d == 32'd2) ||
                         (req_d == 32'd4) || (req_d == 32'd8);
    // nc wraps above 2^31 and no power can qualify
    assign d_big       = req_d[udmf_pkg::DIV_W-1] && (req_d[udmf_pkg::DIV_W-2:0] != '0);
    assign d_three     = (req_d == 32'd3);

    always_comb begin
        unique case (req_d[3:0])
            4'd2:    small_shift = 7'd1;
            4'd4:    small_shift = 7'd2;
            4'd8:    small_shift = 7'd3;
            default: small_shift = 7'd0;
        endcase
    end

    // one bit of each long division per cycle
    assign rem_dbl = {r_rem, 1'b1};
    assign rem_ge  = (rem_dbl >= {1'b0, r_d});
    assign rem_nx  = rem_ge ? udmf_pkg::DIV_W'(rem_dbl - {1'b0, r_d})
                            : rem_dbl[udmf_pkg::DIV_W-1:0];

    assign r_dbl = {r_r, 1'b1};
    assign r_ge  = (r_dbl >= {1'b0, r_nc});
    assign r_nx  = r_ge ? udmf_pkg::DIV_W'(r_dbl - {1'b0, r_nc})
                        : r_dbl[udmf_pkg::DIV_W-1:0];
    assign q_nx  = r_q[udmf_pkg::DIV_W] ? r_q : {r_q[udmf_pkg::DIV_W-1:0], r_ge};

    // 2^p > nc*delta  <=>  floor((2^p-1)/nc) >= delta
    assign delta  = r_d - 32'd1 - r_rem;
    assign hit    = (r_q >= {1'b0, delta});
    assign last_p = r_is3 ? udmf_pkg::LAST_P_THREE : udmf_pkg::LAST_P_OTHER;

    // m = (2^p + delta) / d = floor((2^p-1)/d) + 1
    assign mult        = r_qd + 32'd1;
    assign shift_found = (mult == 32'd1) ? {1'b0, r_p}
                                         : {1'b0, r_p} - udmf_pkg::WORD_BITS;

    // nc = 2^31 - 1 - (2^31 mod d)
    assign t_inc  = {1'b0, r_rem} + 33'd1;
    assign t_mod  = (t_inc == {1'b0, r_d}) ? '0 : t_inc[udmf_pkg::DIV_W-1:0];
    assign nc_pre = udmf_pkg::NC_OTHER - t_mod;

    assign out_free = !r_out_valid || o_res.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            udmf_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    priority if (d_zero || d_pow_small || d_big) n_state = udmf_pkg::S_EMIT;
                    else if (d_three)                            n_state = udmf_pkg::S_SEARCH;
                    else                                         n_state = udmf_pkg::S_PRE;
                end
            end
            udmf_pkg::S_PRE: begin
                if (r_p == udmf_pkg::PRE_LAST) n_state = udmf_pkg::S_SEARCH;
            end
            udmf_pkg::S_SEARCH: begin
                if (hit || (r_p == last_p)) n_state = udmf_pkg::S_EMIT;
            end
            udmf_pkg::S_EMIT: begin
                if (out_free) n_state = udmf_pkg::S_IDLE;
            end
            default: n_state = udmf_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = (r_state == udmf_pkg::S_IDLE);
        out_load = (r_state == udmf_pkg::S_EMIT) && out_free;
    end

    assign accept      = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= udmf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mult   <= r_res_mult;
            r_out_shift  <= r_res_shift;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            udmf_pkg::S_IDLE: begin
                if (accept) begin
                    r_d   <= req_d;
                    r_rem <= '0;
                    r_r   <= '0;
                    r_q   <= '0;
                    r_qd  <= '0;
                    r_p   <= '0;
                    r_is3 <= d_three;
                    r_nc  <= udmf_pkg::NC_THREE;
                    priority if (d_zero) begin
                        r_res_mult   <= '0;
                        r_res_shift  <= '0;
                        r_res_status <= udmf_pkg::STAT_ZERO;
                    end else if (d_pow_small) begin
                        r_res_mult   <= 32'd1;
                        r_res_shift  <= small_shift;
                        r_res_status <= udmf_pkg::STAT_FOUND;
                    end else begin
                        r_res_mult   <= '0;
                        r_res_shift  <= '0;
                        r_res_status <= udmf_pkg::STAT_NONE;
                    end
                end
            end
            udmf_pkg::S_PRE: begin
                if (r_p == udmf_pkg::PRE_LAST) begin
                    r_nc  <= nc_pre;
                    r_rem <= '0;
                    r_p   <= '0;
                end else begin
                    r_rem <= rem_nx;
                    r_p   <= r_p + 6'd1;
                end
            end
            udmf_pkg::S_SEARCH: begin
                if (hit) begin
                    r_res_mult   <= mult;
                    r_res_shift  <= shift_found;
                    r_res_status <= udmf_pkg::STAT_FOUND;
                end else if (r_p == last_p) begin
                    r_res_mult   <= '0;
                    r_res_shift  <= '0;
                    r_res_status <= udmf_pkg::STAT_NONE;
                end else begin
                    r_rem <= rem_nx;
                    r_qd  <= {r_qd[udmf_pkg::MULT_W-2:0], rem_ge};
                    r_r   <= r_nx;
                    r_q   <= q_nx;
                    r_p   <= r_p + 6'd1;
                end
            end
            udmf_pkg::S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.multiplier   = r_out_mult;
    assign o_res.shift_amount = r_out_shift;
    assign o_res.status       = r_out_status;

    // remainder recurrence must stay reduced modulo the divisor
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == udmf_pkg::S_PRE || r_state == udmf_pkg::S_SEARCH) |-> (r_rem < r_d))
        else $error("remainder not reduced");

    // search never runs past the last allowed power
    a_p_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == udmf_pkg::S_SEARCH) |-> (r_p <= last_p))
        else $error("search power out of range");

    // zero divisor goes straight to emit with the zero status
    a_zero_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.divisor == '0)) |=>
        (r_state == udmf_pkg::S_EMIT && r_res_status == udmf_pkg::STAT_ZERO))
        else $error("zero divisor mishandled");

    // a result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> ($stable(r_out_mult) && $stable(r_out_status)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
